// ===== hdl/mi_pkg.sv =====
// ----------------------------------------------------------------------------
// mi_pkg
// Types shared by the modular inverse controller, datapath and top level.
// ----------------------------------------------------------------------------
package mi_pkg;

    // input item
    typedef struct packed {
        logic signed [31:0] operand;
        logic        [30:0] modulus;
    } t_in;

    // result item
    typedef struct packed {
        logic        found;
        logic [30:0] inverse;
    } t_out;

    // datapath operations issued by the controller
    typedef enum logic [2:0] {
        DP_NOP    = 3'd0,
        DP_LOAD   = 3'd1,
        DP_DIV    = 3'd2,
        DP_RFIX   = 3'd3,
        DP_ODD    = 3'd4,
        DP_ESTART = 3'd5,
        DP_EFIN   = 3'd6,
        DP_DONE   = 3'd7
    } t_dp_op;

    // datapath status seen by the controller
    typedef struct packed {
        logic small_n;
        logic n_odd;
        logic b_zero;
        logic cnt_last;
    } t_status;

endpackage

// ===== hdl/mi_ctrl.sv =====
// ----------------------------------------------------------------------------
// mi_ctrl
// Sequencer for reduction, binary GCD or Euclid loop, and result delivery.
// ----------------------------------------------------------------------------
module mi_ctrl
    import mi_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_dp_op  o_op,
    output logic    o_busy
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_RED  = 8'b0000_0010,
        S_RFIX = 8'b0000_0100,
        S_ODD  = 8'b0000_1000,
        S_EVEN = 8'b0001_0000,
        S_EDIV = 8'b0010_0000,
        S_EFIN = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath command
    always_comb begin
        n_state = r_state;
        o_op    = DP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_op    = DP_LOAD;
                    n_state = S_RED;
                end
            end
            S_RED: begin
                if (i_status.small_n) begin
                    n_state = S_DONE;
                end else begin
                    o_op = DP_DIV;
                    if (i_status.cnt_last) begin
                        n_state = S_RFIX;
                    end
                end
            end
            S_RFIX: begin
                o_op    = DP_RFIX;
                n_state = i_status.n_odd ? S_ODD : S_EVEN;
            end
            S_ODD: begin
                if (i_status.b_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_op = DP_ODD;
                end
            end
            S_EVEN: begin
                if (i_status.b_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_op    = DP_ESTART;
                    n_state = S_EDIV;
                end
            end
            S_EDIV: begin
                o_op = DP_DIV;
                if (i_status.cnt_last) begin
                    n_state = S_EFIN;
                end
            end
            S_EFIN: begin
                o_op    = DP_EFIN;
                n_state = S_EVEN;
            end
            S_DONE: begin
                o_op    = DP_DONE;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

`ifndef SYNTH
    // an accepted item always leaves idle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted item did not make the block busy");

    // delivery always returns to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> (r_state == S_IDLE))
        else $error("done state did not return to idle");
`endif

endmodule

// ===== hdl/mi_dp.sv =====
// ----------------------------------------------------------------------------
// mi_dp
// Datapath: bit-serial divider, GCD registers, coefficients and result register.
// ----------------------------------------------------------------------------
module mi_dp
    import mi_pkg::*;
#(
    parameter int MOD_BITS = 31
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dp_op  i_op,
    input  t_in     i_item,
    output t_status o_status,
    output logic    o_valid,
    output t_out    o_result
);

    localparam int W  = MOD_BITS;
    localparam int DW = (MOD_BITS > 32) ? MOD_BITS : 32;
    localparam int CW = $clog2(DW + 1);

    logic [W-1:0]  r_n, r_a, r_b, r_x, r_y, r_d, r_rem, r_t;
    logic [DW-1:0] r_dq;
    logic [CW-1:0] r_cnt;
    logic          r_sgn, r_neg, r_valid;
    t_out          r_out;

    logic [W-1:0]  mod_w;
    logic [31:0]   mag;
    logic [W:0]    rem_sh, t2, t2r, ts;
    logic          q_bit;
    logic [W-1:0]  rem_nx, t_nx;
    logic [W:0]    hx, hy, sxy, syx, sty;
    logic [W-1:0]  half_x, half_y, add_xy, add_yx, add_ty, red_b, res;

    // operand magnitude and masked modulus
    assign mod_w = W'(i_item.modulus);
    assign mag   = i_item.operand[31] ? (~i_item.operand + 32'd1) : i_item.operand;

    // one restoring division step with quotient times x folded in modulo n
    always_comb begin
        rem_sh = {r_rem, r_dq[DW-1]};
        q_bit  = (rem_sh >= {1'b0, r_d});
        rem_nx = q_bit ? W'(rem_sh - {1'b0, r_d}) : W'(rem_sh);
        t2     = {r_t, 1'b0};
        t2r    = (t2 >= {1'b0, r_n}) ? (t2 - {1'b0, r_n}) : t2;
        ts     = t2r + {1'b0, r_x};
        if (q_bit) begin
            t_nx = (ts >= {1'b0, r_n}) ? W'(ts - {1'b0, r_n}) : W'(ts);
        end else begin
            t_nx = W'(t2r);
        end
    end

    // halving and adding modulo n, and sign fixes of the reduced operand and the result
    always_comb begin
        hx     = r_x[0] ? ({1'b0, r_x} + {1'b0, r_n}) : {1'b0, r_x};
        hy     = r_y[0] ? ({1'b0, r_y} + {1'b0, r_n}) : {1'b0, r_y};
        half_x = hx[W:1];
        half_y = hy[W:1];
        sxy    = {1'b0, r_x} + {1'b0, r_y};
        add_xy = (sxy >= {1'b0, r_n}) ? W'(sxy - {1'b0, r_n}) : W'(sxy);
        syx    = sxy;
        add_yx = add_xy;
        sty    = {1'b0, r_t} + {1'b0, r_y};
        add_ty = (sty >= {1'b0, r_n}) ? W'(sty - {1'b0, r_n}) : W'(sty);
        red_b  = (r_sgn && (r_rem != '0)) ? (r_n - r_rem) : r_rem;
        res    = (r_neg && (r_y != '0)) ? (r_n - r_y) : r_y;
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            DP_LOAD: begin
                r_n   <= mod_w;
                r_d   <= mod_w;
                r_sgn <= i_item.operand[31];
                r_dq  <= DW'(mag);
                r_rem <= '0;
                r_t   <= '0;
                r_cnt <= CW'(DW);
            end
            DP_DIV: begin
                r_rem <= rem_nx;
                r_t   <= t_nx;
                r_dq  <= {r_dq[DW-2:0], 1'b0};
                r_cnt <= r_cnt - CW'(1);
            end
            DP_RFIX: begin
                r_b   <= red_b;
                r_a   <= r_n;
                r_x   <= W'(1);
                r_y   <= '0;
                r_neg <= 1'b1;
            end
            DP_ODD: begin
                if (!r_b[0] || !r_a[0]) begin
                    if (!r_b[0]) begin
                        r_b <= r_b >> 1;
                        r_x <= half_x;
                    end
                    if (!r_a[0]) begin
                        r_a <= r_a >> 1;
                        r_y <= half_y;
                    end
                end else if (r_b >= r_a) begin
                    r_x <= add_xy;
                    r_b <= r_b - r_a;
                end else begin
                    r_y <= (syx >= {1'b0, r_n}) ? add_yx : W'(syx);
                    r_a <= r_a - r_b;
                end
            end
            DP_ESTART: begin
                r_dq  <= DW'(r_a);
                r_d   <= r_b;
                r_rem <= '0;
                r_t   <= '0;
                r_cnt <= CW'(DW);
            end
            DP_EFIN: begin
                r_a   <= r_b;
                r_b   <= r_rem;
                r_y   <= r_x;
                r_x   <= add_ty;
                r_neg <= ~r_neg;
            end
            DP_DONE: begin
                if ((r_n >= W'(2)) && (r_a == W'(1))) begin
                    r_out.found   <= 1'b1;
                    r_out.inverse <= 31'(res);
                end else begin
                    r_out.found   <= 1'b0;
                    r_out.inverse <= '0;
                end
            end
            default: begin
            end
        endcase
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_op == DP_DONE);
        end
    end

    assign o_status.small_n  = (r_n < W'(2));
    assign o_status.n_odd    = r_n[0];
    assign o_status.b_zero   = (r_b == '0);
    assign o_status.cnt_last = (r_cnt == CW'(1));
    assign o_valid  = r_valid;
    assign o_result = r_out;

`ifndef SYNTH
    // a division step always leaves a remainder below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == DP_DIV) |=> (r_rem < r_d))
        else $error("remainder not below divisor");

    // binary gcd keeps both coefficients reduced
    a_coef_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == DP_ODD) |=> ((r_x < r_n) && (r_y < r_n)))
        else $error("coefficient not reduced modulo n");
`endif

endmodule

// ===== hdl/modular_inverse_top.sv =====
// Flow: the operand is loaded, reduced modulo n by D = max(MOD_BITS, 32) divider steps
// and sign-fixed; then binary GCD runs for an odd modulus, or for an even modulus
// Euclid steps run, each a start, D divider steps and a finish, until an exit check;
// a modulus below two skips the reduction and goes straight to result delivery.
// Throughput: one item at a time, set by the shared bit-serial divider and GCD loop.
// Reset returns the sequencer to idle and clears the result strobe; the result is
// shown for one cycle and the receiver cannot stall it.
// ----------------------------------------------------------------------------
// modular_inverse_top
// Modular inverse of a signed operand by binary extended GCD or Euclid.
// ----------------------------------------------------------------------------
module modular_inverse_top
    import mi_pkg::*;
#(
    parameter int MOD_BITS = 31
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_item,
    output logic busy,
    output logic o_valid,
    output t_out o_result
);

    t_dp_op  op;
    t_status status;

    // sequencer
    mi_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_op     (op),
        .o_busy   (busy)
    );

    // arithmetic
    mi_dp #(
        .MOD_BITS (MOD_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (op),
        .i_item   (i_item),
        .o_status (status),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

`ifndef SYNTH
    // a result is only delivered once the block has gone idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");
`endif

endmodule
